FILE: rtl/cer_pkg.sv
// ----------------------------------------------------------------------------
// Column escape RLE encoder package
// Shared constants, token codes, byte flip function and control structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cer_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int ROW_W       = $clog2(MAX_ROWS + 1);
  localparam int IDX_W       = $clog2(MAX_ROWS);
  localparam int HIST_AW     = 8;
  localparam int CNT_W       = 7;
  localparam int LITERAL_MAX = 3;
  localparam int TRIPLET_LEN = 3;

  typedef enum logic [1:0] {
    TOK_HEADER  = 2'd0,
    TOK_LITERAL = 2'd1,
    TOK_ESCAPE  = 2'd2
  } tok_kind_t;

  typedef struct packed {
    logic       inc;
    logic       close;
    logic [7:0] value;
  } hist_cmd_t;

  typedef struct packed {
    logic       ready;
    logic       done;
    logic [7:0] escape;
  } hist_stat_t;

  typedef struct packed {
    logic       wr;
    logic [7:0] wr_data;
    logic       start;
    logic [7:0] escape;
  } rle_cmd_t;

  typedef struct packed {
    logic full;
    logic done;
  } rle_stat_t;

  function automatic logic [7:0] flip_byte(input logic [7:0] v);
    logic [7:0] r;
    for (int b = 0; b < 8; b++) begin
      r[7 - b] = v[b];
    end
    return ~r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cer_if.sv
// ----------------------------------------------------------------------------
// Column escape RLE encoder channel interfaces
// Valid/ready channels for pixel bytes in and encoded tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

interface cer_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_byte;
  logic       edge_column;
  logic       end_of_column;

  modport source (output valid, output pixel_byte, output edge_column,
                  output end_of_column, input ready);
  modport sink (input valid, input pixel_byte, input edge_column,
                input end_of_column, output ready);
endinterface

interface cer_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] token_kind;
  logic [7:0] token_byte;
  logic [7:0] run_count;
  logic [7:0] column_bytes;
  logic       last_token;

  modport source (output valid, output token_kind, output token_byte,
                  output run_count, output column_bytes, output last_token,
                  input ready);
  modport sink (input valid, input token_kind, input token_byte,
                input run_count, input column_bytes, input last_token,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/column_escape_rle_encoder.sv
// ----------------------------------------------------------------------------
// Column escape RLE encoder
// Stores and histograms one bitmap column, picks the escape byte and emits
// a header token followed by literal and escaped run tokens.
// ----------------------------------------------------------------------------
// Pixel bytes are taken one per cycle while a column loads.
// After the end-of-column byte, input stalls for an escape search over all 256
// histogram entries and for two scans of the column store, one to size the
// column and one to emit its tokens, plus any output stalls.
// The first token, the header, leaves after the escape search and the first scan.
// After reset the histogram memory is cleared with input held off.
`default_nettype none

module column_escape_rle_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  cer_in_if.sink          in_chan,
  cer_out_if.source       out_chan
);

  typedef enum logic [2:0] {
    PH_LOAD = 3'b001,
    PH_HIST = 3'b010,
    PH_ENC  = 3'b100
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [7:0]          edge_mask_r, edge_mask_nxt;
  logic                accept;
  logic [7:0]          flipped;
  logic [7:0]          masked;
  cer_pkg::hist_cmd_t  hist_cmd;
  cer_pkg::hist_stat_t hist_stat;
  cer_pkg::rle_cmd_t   rle_cmd;
  cer_pkg::rle_stat_t  rle_stat;

  assign in_chan.ready = (phase_r == PH_LOAD) && hist_stat.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign flipped       = cer_pkg::flip_byte(in_chan.pixel_byte);
  assign masked        = in_chan.edge_column ? (flipped & edge_mask_r) : flipped;
  assign edge_mask_nxt = cfg_wr_en ? cfg_wr_data : edge_mask_r;

  assign hist_cmd.inc   = accept && !rle_stat.full;
  assign hist_cmd.close = accept && in_chan.end_of_column;
  assign hist_cmd.value = masked;

  assign rle_cmd.wr      = accept;
  assign rle_cmd.wr_data = masked;
  assign rle_cmd.start   = (phase_r == PH_HIST) && hist_stat.done;
  assign rle_cmd.escape  = hist_stat.escape;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_LOAD: begin
        if (accept && in_chan.end_of_column) begin
          phase_nxt = PH_HIST;
        end
      end
      PH_HIST: begin
        if (hist_stat.done) begin
          phase_nxt = PH_ENC;
        end
      end
      PH_ENC: begin
        if (rle_stat.done) begin
          phase_nxt = PH_LOAD;
        end
      end
      default: begin
        phase_nxt = PH_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LOAD;
      edge_mask_r <= 8'hFF;
    end else begin
      phase_r     <= phase_nxt;
      edge_mask_r <= edge_mask_nxt;
    end
  end

  cer_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (hist_cmd),
    .stat  (hist_stat)
  );

  cer_rle u_rle (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (rle_cmd),
    .stat     (rle_stat),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire

FILE: rtl/cer_hist.sv
// ----------------------------------------------------------------------------
// Byte histogram and escape search
// 256-entry count memory with forwarded increments, a clearing pass after
// reset and a minimum search that also clears each entry it reads.
// ----------------------------------------------------------------------------
`default_nettype none

module cer_hist (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cer_pkg::hist_cmd_t cmd,
  output cer_pkg::hist_stat_t     stat
);

  typedef enum logic [4:0] {
    H_CLR   = 5'b00001,
    H_IDLE  = 5'b00010,
    H_DRAIN = 5'b00100,
    H_SWEEP = 5'b01000,
    H_TAIL  = 5'b10000
  } hstate_t;

  localparam logic [cer_pkg::HIST_AW-1:0] LAST_ADDR = '1;

  logic [cer_pkg::CNT_W-1:0]   mem [2**cer_pkg::HIST_AW];

  hstate_t                     state_r, state_nxt;
  logic [cer_pkg::HIST_AW-1:0] idx_r, idx_nxt;
  logic [cer_pkg::CNT_W-1:0]   rdata_r;
  logic                        s1_valid_r;
  logic [cer_pkg::HIST_AW-1:0] s1_addr_r;
  logic                        lw_valid_r;
  logic [cer_pkg::HIST_AW-1:0] lw_addr_r;
  logic [cer_pkg::CNT_W-1:0]   lw_data_r;
  logic                        cmp_valid_r;
  logic [cer_pkg::HIST_AW-1:0] cmp_idx_r;
  logic [cer_pkg::CNT_W-1:0]   best_cnt_r;
  logic [cer_pkg::HIST_AW-1:0] best_idx_r;
  logic                        done_r;

  logic                        rd_en;
  logic [cer_pkg::HIST_AW-1:0] rd_addr;
  logic                        wr_en;
  logic [cer_pkg::HIST_AW-1:0] wr_addr;
  logic [cer_pkg::CNT_W-1:0]   wr_data;
  logic [cer_pkg::CNT_W-1:0]   cur_cnt;
  logic [cer_pkg::CNT_W-1:0]   inc_cnt;

  assign cur_cnt = (lw_valid_r && (lw_addr_r == s1_addr_r)) ? lw_data_r : rdata_r;
  assign inc_cnt = cur_cnt + cer_pkg::CNT_W'(1);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    rd_en     = 1'b0;
    rd_addr   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r;
    wr_data   = '0;
    unique case (state_r)
      H_CLR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_r + cer_pkg::HIST_AW'(1);
        if (idx_r == LAST_ADDR) begin
          state_nxt = H_IDLE;
        end
      end
      H_IDLE: begin
        if (cmd.inc) begin
          rd_en   = 1'b1;
          rd_addr = cmd.value;
        end
        if (cmd.close) begin
          state_nxt = H_DRAIN;
        end
      end
      H_DRAIN: begin
        state_nxt = H_SWEEP;
      end
      H_SWEEP: begin
        rd_en   = 1'b1;
        wr_en   = 1'b1;
        idx_nxt = idx_r + cer_pkg::HIST_AW'(1);
        if (idx_r == LAST_ADDR) begin
          state_nxt = H_TAIL;
        end
      end
      H_TAIL: begin
        state_nxt = H_IDLE;
      end
      default: begin
        state_nxt = H_CLR;
      end
    endcase
    if (s1_valid_r) begin
      wr_en   = 1'b1;
      wr_addr = s1_addr_r;
      wr_data = inc_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= H_CLR;
      idx_r       <= '0;
      s1_valid_r  <= 1'b0;
      lw_valid_r  <= 1'b0;
      cmp_valid_r <= 1'b0;
      done_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      s1_valid_r  <= (state_r == H_IDLE) && cmd.inc;
      lw_valid_r  <= s1_valid_r;
      cmp_valid_r <= (state_r == H_SWEEP);
      done_r      <= (state_r == H_TAIL);
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r <= cmd.value;
    lw_addr_r <= s1_addr_r;
    lw_data_r <= inc_cnt;
    cmp_idx_r <= idx_r;
    if (cmp_valid_r && ((cmp_idx_r == '0) || (rdata_r < best_cnt_r))) begin
      best_cnt_r <= rdata_r;
      best_idx_r <= cmp_idx_r;
    end
  end

  assign stat.ready  = (state_r == H_IDLE);
  assign stat.done   = done_r;
  assign stat.escape = best_idx_r;

endmodule

`default_nettype wire

FILE: rtl/cer_rle.sv
// ----------------------------------------------------------------------------
// Column store and run-length token sequencer
// Holds the column bytes and scans them twice: once to size the column and
// send the header, once to emit the run tokens, all via an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cer_rle (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cer_pkg::rle_cmd_t cmd,
  output cer_pkg::rle_stat_t     stat,
  cer_out_if.source              out_chan
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_FIN  = 5'b01000,
    S_HDR  = 5'b10000
  } rstate_t;

  logic [7:0]                mem [cer_pkg::MAX_ROWS];

  rstate_t                   state_r, state_nxt;
  logic                      pass_r, pass_nxt;
  logic [cer_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]                prev_r, prev_nxt;
  logic [cer_pkg::ROW_W-1:0] run_r, run_nxt;
  logic [7:0]                bytes_r, bytes_nxt;
  logic [7:0]                esc_r, esc_nxt;
  logic [cer_pkg::ROW_W-1:0] row_cnt_r;
  logic [7:0]                rdata_r;

  logic                      ov_r;
  cer_pkg::tok_kind_t        kind_r;
  logic [7:0]                byte_r;
  logic [7:0]                count_r;
  logic [7:0]                colb_r;
  logic                      last_r;

  logic                      full;
  logic                      store_wr;
  logic                      rd_en;
  logic                      clear_rows;
  logic                      out_free;
  logic [cer_pkg::ROW_W-1:0] row_m1;
  logic [cer_pkg::IDX_W-1:0] last_idx;
  logic                      first;
  logic                      brk;
  logic                      at_last;
  logic                      tok_esc;
  cer_pkg::tok_kind_t        tok_kind;
  logic [7:0]                tok_count;
  logic [7:0]                tok_len;

  logic                      emit;
  cer_pkg::tok_kind_t        emit_kind;
  logic [7:0]                emit_byte;
  logic [7:0]                emit_count;
  logic [7:0]                emit_bytes;
  logic                      emit_last;
  logic                      done;

  assign full     = (row_cnt_r == cer_pkg::ROW_W'(cer_pkg::MAX_ROWS));
  assign store_wr = cmd.wr && !full;
  assign out_free = !ov_r || out_chan.ready;
  assign row_m1   = row_cnt_r - cer_pkg::ROW_W'(1);
  assign last_idx = row_m1[cer_pkg::IDX_W-1:0];
  assign first    = (idx_r == '0);
  assign brk      = !first && (rdata_r != prev_r);
  assign at_last  = (idx_r == last_idx);

  assign tok_esc   = (run_r > cer_pkg::ROW_W'(cer_pkg::LITERAL_MAX)) || (prev_r == esc_r);
  assign tok_kind  = tok_esc ? cer_pkg::TOK_ESCAPE : cer_pkg::TOK_LITERAL;
  assign tok_count = tok_esc ? 8'(run_r - cer_pkg::ROW_W'(1)) : 8'(run_r);
  assign tok_len   = tok_esc ? 8'(cer_pkg::TRIPLET_LEN) : 8'(run_r);

  always_comb begin
    state_nxt  = state_r;
    pass_nxt   = pass_r;
    idx_nxt    = idx_r;
    prev_nxt   = prev_r;
    run_nxt    = run_r;
    bytes_nxt  = bytes_r;
    esc_nxt    = esc_r;
    rd_en      = 1'b0;
    clear_rows = 1'b0;
    done       = 1'b0;
    emit       = 1'b0;
    emit_kind  = tok_kind;
    emit_byte  = prev_r;
    emit_count = tok_count;
    emit_bytes = '0;
    emit_last  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          esc_nxt   = cmd.escape;
          pass_nxt  = 1'b0;
          bytes_nxt = '0;
          idx_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (!(brk && pass_r && !out_free)) begin
          if (brk) begin
            if (pass_r) begin
              emit = 1'b1;
            end else begin
              bytes_nxt = bytes_r + tok_len;
            end
          end
          prev_nxt = rdata_r;
          run_nxt  = (first || brk) ? cer_pkg::ROW_W'(1) : run_r + cer_pkg::ROW_W'(1);
          if (at_last) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt   = idx_r + cer_pkg::IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      S_FIN: begin
        if (!pass_r) begin
          bytes_nxt = bytes_r + tok_len;
          state_nxt = S_HDR;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          clear_rows = 1'b1;
          done       = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_HDR: begin
        if (out_free) begin
          emit       = 1'b1;
          emit_kind  = cer_pkg::TOK_HEADER;
          emit_byte  = esc_r;
          emit_count = '0;
          emit_bytes = bytes_r;
          pass_nxt   = 1'b1;
          idx_nxt    = '0;
          state_nxt  = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem[row_cnt_r[cer_pkg::IDX_W-1:0]] <= cmd.wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      row_cnt_r <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clear_rows) begin
        row_cnt_r <= '0;
      end else if (store_wr) begin
        row_cnt_r <= row_cnt_r + cer_pkg::ROW_W'(1);
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_chan.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pass_r  <= pass_nxt;
    idx_r   <= idx_nxt;
    prev_r  <= prev_nxt;
    run_r   <= run_nxt;
    bytes_r <= bytes_nxt;
    esc_r   <= esc_nxt;
    if (emit) begin
      kind_r  <= emit_kind;
      byte_r  <= emit_byte;
      count_r <= emit_count;
      colb_r  <= emit_bytes;
      last_r  <= emit_last;
    end
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.token_kind   = kind_r;
  assign out_chan.token_byte   = byte_r;
  assign out_chan.run_count    = count_r;
  assign out_chan.column_bytes = colb_r;
  assign out_chan.last_token   = last_r;

  assign stat.full = full;
  assign stat.done = done;

endmodule

`default_nettype wire

FILE: rtl/cer_checker.sv
// ----------------------------------------------------------------------------
// Column escape RLE encoder port checker
// Watches the top-level ports for token and handshake consistency.
// ----------------------------------------------------------------------------
`default_nettype none

module cer_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_eoc,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [7:0] out_byte,
  input wire logic [7:0] out_count,
  input wire logic [7:0] out_bytes,
  input wire logic       out_last
);

  logic is_header;
  logic is_literal;

  assign is_header  = out_valid && (out_kind == cer_pkg::TOK_HEADER);
  assign is_literal = out_valid && (out_kind == cer_pkg::TOK_LITERAL);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
      && $stable(out_count) && $stable(out_bytes) && $stable(out_last))
    else $error("Stalled token transaction changed.");

  a_stall_after_eoc: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_eoc |=> !in_ready)
    else $error("Input accepted straight after the end of a column.");

  a_header_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    is_header |-> !out_last && (out_count == 8'd0)
      && (out_bytes <= 8'(cer_pkg::MAX_ROWS)))
    else $error("Malformed column header.");

  a_literal_count: assert property (@(posedge clk) disable iff (!rst_n)
    is_literal |-> (out_count != 8'd0) && (out_count <= 8'(cer_pkg::LITERAL_MAX))
      && (out_bytes == 8'd0))
    else $error("Literal token with an invalid repeat count.");

endmodule

bind column_escape_rle_encoder cer_checker u_cer_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_eoc    (in_chan.end_of_column),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_kind  (out_chan.token_kind),
  .out_byte  (out_chan.token_byte),
  .out_count (out_chan.run_count),
  .out_bytes (out_chan.column_bytes),
  .out_last  (out_chan.last_token)
);

`default_nettype wire

FILE: dv/column_escape_rle_encoder_tb.sv
// ----------------------------------------------------------------------------
// Column escape RLE encoder testbench
// Drives bitmap columns through the valid/ready input channel and stalls the
// token output at random. Each accepted byte is fed to an in-bench model of
// the escape search and run encoder. Every token that leaves the block is
// compared field by field with the oldest predicted token. The edge mask is
// changed between phases, only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module column_escape_rle_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 400;
  localparam int PHASE_ITEMS   = 24;
  localparam int RUN_LIMIT     = 256;

  typedef struct packed {
    cer_pkg::tok_kind_t kind;
    logic [7:0]         tok_byte;
    logic [7:0]         count;
    logic [7:0]         nbytes;
    logic               last;
  } token_t;

  class rle_token_tracker;
    token_t     expected_tokens[$];
    logic [7:0] edge_mask;
    logic [7:0] rows_store[cer_pkg::MAX_ROWS];
    logic [6:0] byte_hist[256];
    logic [5:0] row_count;
    int         errors;
    int         columns;
    int         dropped_bytes;
    int         literal_tokens;
    int         escaped_tokens;
    int         checked;

    function new();
      edge_mask      = 8'hFF;
      row_count      = '0;
      errors         = 0;
      columns        = 0;
      dropped_bytes  = 0;
      literal_tokens = 0;
      escaped_tokens = 0;
      checked        = 0;
      foreach (byte_hist[j]) byte_hist[j] = '0;
    endfunction

    function void set_mask(logic [7:0] m);
      edge_mask = m;
    endfunction

    function void note_pixel(logic [7:0] raw, logic edge_col, logic eoc);
      logic [7:0] v;
      v = {<<{raw}};
      v = ~v;
      if (edge_col) v = v & edge_mask;
      if (row_count < cer_pkg::MAX_ROWS) begin
        rows_store[row_count] = v;
        byte_hist[v] = byte_hist[v] + 7'd1;
        row_count = row_count + 6'd1;
      end else begin
        dropped_bytes++;
      end
      if (eoc) encode_column();
    endfunction

    function void encode_column();
      token_t     runs[$];
      token_t     t;
      logic [7:0] esc;
      logic [7:0] cur;
      int         run;
      int         nbytes;
      esc = 8'd0;
      for (int j = 1; j < 256; j++) begin
        if (byte_hist[j] < byte_hist[esc]) esc = 8'(j);
      end
      run = 1;
      nbytes = 0;
      for (int i = 0; i < row_count; i++) begin
        cur = rows_store[i];
        if (i + 1 < row_count && rows_store[i + 1] == cur && run < RUN_LIMIT) begin
          run++;
          continue;
        end
        t.tok_byte = cur;
        t.nbytes   = 8'd0;
        t.last     = 1'b0;
        if (run > cer_pkg::LITERAL_MAX || cur == esc) begin
          t.kind  = cer_pkg::TOK_ESCAPE;
          t.count = 8'(run - 1);
          nbytes += cer_pkg::TRIPLET_LEN;
          escaped_tokens++;
        end else begin
          t.kind  = cer_pkg::TOK_LITERAL;
          t.count = 8'(run);
          nbytes += run;
          literal_tokens++;
        end
        runs.push_back(t);
        run = 1;
      end
      t.kind     = cer_pkg::TOK_HEADER;
      t.tok_byte = esc;
      t.count    = 8'd0;
      t.nbytes   = 8'(nbytes);
      t.last     = (runs.size() == 0);
      if (runs.size() > 0) runs[runs.size() - 1].last = 1'b1;
      expected_tokens.push_back(t);
      foreach (runs[r]) expected_tokens.push_back(runs[r]);
      foreach (byte_hist[j]) byte_hist[j] = '0;
      row_count = '0;
      columns++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_token(token_t got);
      token_t want;
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected token kind %0d byte %02h", got.kind, got.tok_byte));
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (got.kind !== want.kind)
        report($sformatf("token_kind %0d, expected %0d", got.kind, want.kind));
      if (got.tok_byte !== want.tok_byte)
        report($sformatf("token_byte %02h, expected %02h", got.tok_byte, want.tok_byte));
      if (got.count !== want.count)
        report($sformatf("run_count %0d, expected %0d", got.count, want.count));
      if (got.nbytes !== want.nbytes)
        report($sformatf("column_bytes %0d, expected %0d", got.nbytes, want.nbytes));
      if (got.last !== want.last)
        report($sformatf("last_token %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  cer_in_if  in_chan();
  cer_out_if out_chan();

  column_escape_rle_encoder dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  rle_token_tracker tracker = new();

  bit quiet;
  int items_sent;
  int idle_cycles;
  int masks_written;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    token_t got;
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (in_chan.valid && in_chan.ready)
        tracker.note_pixel(in_chan.pixel_byte, in_chan.edge_column, in_chan.end_of_column);
      if (out_chan.valid && out_chan.ready) begin
        got.kind     = cer_pkg::tok_kind_t'(out_chan.token_kind);
        got.tok_byte = out_chan.token_byte;
        got.count    = out_chan.run_count;
        got.nbytes   = out_chan.column_bytes;
        got.last     = out_chan.last_token;
        tracker.check_token(got);
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timed out with %0d tokens outstanding.", tracker.expected_tokens.size());
        $display("** column_escape_rle_encoder: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    int h;
    int n;
    out_chan.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      h = $urandom_range(1, 12);
      out_chan.ready <= 1'b1;
      repeat (h) @(negedge clk);
      n = idle_len();
      if (n > 0) begin
        out_chan.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic send_pixel(logic [7:0] raw, logic edge_col, logic eoc);
    int gap;
    gap = idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid         <= 1'b1;
    in_chan.pixel_byte    <= raw;
    in_chan.edge_column   <= edge_col;
    in_chan.end_of_column <= eoc;
    do @(posedge clk); while (!in_chan.ready);
    items_sent++;
  endtask

  task automatic send_column(int len, logic edge_col, bit noisy);
    logic [7:0] raw;
    logic       e;
    int         i;
    int         run;
    int         r;
    i = 0;
    while (i < len) begin
      raw = 8'($urandom);
      r = $urandom_range(0, 99);
      run = (r < 70) ? $urandom_range(1, 3) : (r < 92) ? $urandom_range(4, 8)
                                                       : $urandom_range(9, 20);
      for (int k = 0; k < run && i < len; k++) begin
        e = noisy ? 1'($urandom) : edge_col;
        if (noisy && $urandom_range(0, 2) == 0) raw = 8'($urandom);
        send_pixel(raw, e, i == len - 1);
        i++;
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (tracker.expected_tokens.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mask(logic [7:0] m);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    tracker.set_mask(m);
    masks_written++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] masks[6];
    int         phase_start;
    int         len;
    rst_n                 = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_wr_data           = 8'd0;
    in_chan.valid         = 1'b0;
    in_chan.pixel_byte    = 8'd0;
    in_chan.edge_column   = 1'b0;
    in_chan.end_of_column = 1'b0;
    quiet                 = 1'b0;
    items_sent            = 0;
    idle_cycles           = 0;
    masks_written         = 0;
    masks = '{8'h00, 8'h0F, 8'h80, 8'h01, 8'h00, 8'hFF};
    masks[4] = 8'($urandom);
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    send_pixel(8'h00, 1'b0, 1'b1);
    send_pixel(8'hFF, 1'b1, 1'b1);
    repeat (5) send_pixel(8'h3C, 1'b0, 1'b0);
    send_pixel(8'h81, 1'b0, 1'b0);
    repeat (2) send_pixel(8'h42, 1'b1, 1'b0);
    repeat (2) send_pixel(8'h99, 1'b0, 1'b0);
    send_pixel(8'h99, 1'b0, 1'b1);
    for (int b = 0; b < 8; b++) send_pixel(8'h01 << b, 1'(b), b == 7);

    for (int p = 0; p < 6; p++) begin
      settle();
      write_mask(masks[p]);
      quiet = (p % 3 == 2);
      phase_start = items_sent;
      if (p == 0) send_column(cer_pkg::MAX_ROWS + 2, 1'b1, 1'b0);
      while (items_sent - phase_start < PHASE_ITEMS) begin
        len = ($urandom_range(0, 99) < 12)
                ? $urandom_range(cer_pkg::MAX_ROWS - 2, cer_pkg::MAX_ROWS + 2)
                : $urandom_range(1, 12);
        send_column(len, $urandom_range(0, 9) < 3, $urandom_range(0, 99) < 15);
      end
    end
    quiet = 1'b0;
    settle();

    $display("Run covered %0d pixel bytes in %0d columns, %0d dropped on a full store.",
             items_sent, tracker.columns, tracker.dropped_bytes);
    $display("Checked %0d tokens (%0d literal, %0d escaped runs) over %0d edge masks.",
             tracker.checked, tracker.literal_tokens, tracker.escaped_tokens, masks_written);
    if (tracker.errors == 0 && tracker.expected_tokens.size() == 0) begin
      $display("** column_escape_rle_encoder: PASSED **");
    end else begin
      $display("** column_escape_rle_encoder: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
